>>> hdl/kda_pkg.sv
// Shared constants, types and command/status structs for the keyed duration accumulator.
package kda_pkg;

  // Table geometry.
  localparam int unsigned ENTRIES = 64;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  // Field widths.
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned TOTAL_W  = 64;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned EIDX_W   = 6;
  localparam int unsigned DATA_W   = TOTAL_W + COUNT_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_SCAN,
    CTRL_WAIT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic issue;
    logic do_update;
    logic do_insert;
    logic do_drop;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic scan_done;
    logic full;
  } dp_status_t;

endpackage

>>> hdl/kda_sample_if.sv
// Input channel carrying one sample beat: address key and duration.
interface kda_sample_if;
  logic                         valid;
  logic                         ready;
  logic [kda_pkg::KEY_W-1:0]    key_address;
  logic [kda_pkg::TOTAL_W-1:0]  duration_ticks;

  modport source (output valid, output key_address, output duration_ticks, input ready);
  modport sink   (input valid, input key_address, input duration_ticks, output ready);
endinterface

>>> hdl/kda_result_if.sv
// Output channel carrying one result beat: status, slot, total and count.
interface kda_result_if;
  logic                          valid;
  logic                          ready;
  logic [kda_pkg::STATUS_W-1:0]  status;
  logic [kda_pkg::EIDX_W-1:0]    entry_index;
  logic [kda_pkg::TOTAL_W-1:0]   total_ticks;
  logic [kda_pkg::COUNT_W-1:0]   call_count;

  modport source (output valid, output status, output entry_index, output total_ticks,
                  output call_count, input ready);
  modport sink   (input valid, input status, input entry_index, input total_ticks,
                  input call_count, output ready);
endinterface

>>> hdl/kda_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module kda_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]              wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/kda_ctrl.sv
// Controller: sequences the key scan, the table update and the result handoff.
module kda_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  kda_pkg::dp_status_t status_i,
  output kda_pkg::dp_cmd_t    cmd_o
);

  kda_pkg::ctrl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;

  // State and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kda_pkg::CTRL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      kda_pkg::CTRL_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = kda_pkg::CTRL_SCAN;
        end
      end
      kda_pkg::CTRL_SCAN: begin
        if (status_i.hit) begin
          cmd_o.do_update = 1'b1;
          state_d         = kda_pkg::CTRL_WAIT;
        end else if (status_i.scan_done) begin
          // Every filled slot compared without a match.
          if (status_i.full) begin
            cmd_o.do_drop = 1'b1;
          end else begin
            cmd_o.do_insert = 1'b1;
          end
          state_d = kda_pkg::CTRL_WAIT;
        end else begin
          cmd_o.issue = 1'b1;
        end
      end
      kda_pkg::CTRL_WAIT: begin
        // Move the result into the output register once it is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = kda_pkg::CTRL_IDLE;
        end
      end
      default: begin
        state_d = kda_pkg::CTRL_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/kda_dp.sv
// Datapath: key and data memories, scan counters, update arithmetic and result registers.
module kda_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [kda_pkg::KEY_W-1:0]     key_address_i,
  input  logic [kda_pkg::TOTAL_W-1:0]   duration_ticks_i,
  input  kda_pkg::dp_cmd_t              cmd_i,
  output kda_pkg::dp_status_t           status_o,
  output logic [kda_pkg::STATUS_W-1:0]  status_field_o,
  output logic [kda_pkg::EIDX_W-1:0]    entry_index_o,
  output logic [kda_pkg::TOTAL_W-1:0]   total_ticks_o,
  output logic [kda_pkg::COUNT_W-1:0]   call_count_o
);

  // Control state.
  logic [kda_pkg::CNT_W-1:0] fill_q, fill_d;
  logic [kda_pkg::CNT_W-1:0] scan_q, scan_d;
  logic                      cmp_vld_q, cmp_vld_d;

  // Payload registers.
  logic [kda_pkg::KEY_W-1:0]   key_q;
  logic [kda_pkg::TOTAL_W-1:0] dur_q;
  logic [kda_pkg::IDX_W-1:0]   cmp_idx_q;
  kda_pkg::status_e            res_status_q, res_status_d;
  logic [kda_pkg::EIDX_W-1:0]  res_idx_q, res_idx_d;
  logic [kda_pkg::TOTAL_W-1:0] res_total_q, res_total_d;
  logic [kda_pkg::COUNT_W-1:0] res_count_q, res_count_d;
  kda_pkg::status_e            out_status_q;
  logic [kda_pkg::EIDX_W-1:0]  out_idx_q;
  logic [kda_pkg::TOTAL_W-1:0] out_total_q;
  logic [kda_pkg::COUNT_W-1:0] out_count_q;

  // Memory ports.
  logic [kda_pkg::KEY_W-1:0]   rd_key;
  logic [kda_pkg::DATA_W-1:0]  rd_data;
  logic [kda_pkg::TOTAL_W-1:0] rd_total;
  logic [kda_pkg::COUNT_W-1:0] rd_count;
  logic [kda_pkg::IDX_W-1:0]   rd_addr;
  logic [kda_pkg::IDX_W-1:0]   fill_addr;
  logic                        data_we;
  logic [kda_pkg::IDX_W-1:0]   data_waddr;
  logic [kda_pkg::DATA_W-1:0]  data_wdata;

  // Update arithmetic.
  logic [kda_pkg::TOTAL_W-1:0] upd_total;
  logic [kda_pkg::COUNT_W-1:0] upd_count;

  assign rd_addr   = scan_q[kda_pkg::IDX_W-1:0];
  assign fill_addr = fill_q[kda_pkg::IDX_W-1:0];
  assign rd_total  = rd_data[kda_pkg::DATA_W-1:kda_pkg::COUNT_W];
  assign rd_count  = rd_data[kda_pkg::COUNT_W-1:0];

  assign upd_total = rd_total + dur_q;
  assign upd_count = (rd_count == kda_pkg::COUNT_MAX) ? rd_count
                                                      : rd_count + kda_pkg::COUNT_W'(1);

  // Status toward the controller.
  assign status_o.hit       = cmp_vld_q && (rd_key == key_q);
  assign status_o.scan_done = (scan_q == fill_q);
  assign status_o.full      = (fill_q == kda_pkg::CNT_W'(kda_pkg::ENTRIES));

  // Memory write selection: a hit rewrites its slot, an insert appends at the fill count.
  assign data_we    = cmd_i.do_update || cmd_i.do_insert;
  assign data_waddr = cmd_i.do_update ? cmp_idx_q : fill_addr;
  assign data_wdata = cmd_i.do_update ? {upd_total, upd_count}
                                      : {dur_q, kda_pkg::COUNT_W'(1)};

  kda_ram #(
    .WIDTH (kda_pkg::KEY_W),
    .DEPTH (kda_pkg::ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.do_insert),
    .waddr_i (fill_addr),
    .wdata_i (key_q),
    .raddr_i (rd_addr),
    .rdata_o (rd_key)
  );

  kda_ram #(
    .WIDTH (kda_pkg::DATA_W),
    .DEPTH (kda_pkg::ENTRIES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wdata_i (data_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Next values of the scan counters and the fill count.
  always_comb begin
    fill_d    = fill_q;
    scan_d    = scan_q;
    cmp_vld_d = cmd_i.issue;
    if (cmd_i.start) begin
      scan_d = '0;
    end else if (cmd_i.issue) begin
      scan_d = scan_q + kda_pkg::CNT_W'(1);
    end
    if (cmd_i.do_insert) begin
      fill_d = fill_q + kda_pkg::CNT_W'(1);
    end
  end

  // Result of the current sample.
  always_comb begin
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_total_d  = res_total_q;
    res_count_d  = res_count_q;
    if (cmd_i.do_update) begin
      res_status_d = kda_pkg::ST_UPDATED;
      res_idx_d    = kda_pkg::EIDX_W'(cmp_idx_q);
      res_total_d  = upd_total;
      res_count_d  = upd_count;
    end else if (cmd_i.do_insert) begin
      res_status_d = kda_pkg::ST_INSERTED;
      res_idx_d    = kda_pkg::EIDX_W'(fill_q);
      res_total_d  = dur_q;
      res_count_d  = kda_pkg::COUNT_W'(1);
    end else if (cmd_i.do_drop) begin
      res_status_d = kda_pkg::ST_FULL;
      res_idx_d    = '0;
      res_total_d  = '0;
      res_count_d  = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      scan_q    <= scan_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q <= key_address_i;
      dur_q <= duration_ticks_i;
    end
    if (cmd_i.issue) begin
      cmp_idx_q <= rd_addr;
    end
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_total_q  <= res_total_d;
    res_count_q  <= res_count_d;
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_idx_q    <= res_idx_q;
      out_total_q  <= res_total_q;
      out_count_q  <= res_count_q;
    end
  end

  assign status_field_o = out_status_q;
  assign entry_index_o  = out_idx_q;
  assign total_ticks_o  = out_total_q;
  assign call_count_o   = out_count_q;

`ifndef SYNTHESIS
  // The fill count never passes the table depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= kda_pkg::CNT_W'(kda_pkg::ENTRIES))
    else $error("fill count beyond table depth");

  // An insert grows the table by exactly one slot.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_insert |=> fill_q == $past(fill_q) + kda_pkg::CNT_W'(1))
    else $error("insert did not advance the fill count");

  // A sample is dropped only when the table is full.
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_drop |-> fill_q == kda_pkg::CNT_W'(kda_pkg::ENTRIES))
    else $error("sample dropped while table has room");

  // The scan never reads past the filled slots.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> scan_q < fill_q)
    else $error("scan issued beyond filled slots");
`endif

endmodule

>>> hdl/keyed_duration_accumulator.sv
// Top level: keyed duration accumulator with a scanned key table.
//
//   Channel    Dir  Beat contents
//   sample_i   in   key_address[63:0], duration_ticks[63:0]
//   result_o   out  status[1:0], entry_index[5:0], total_ticks[63:0], call_count[31:0]
//
// A miss scans every filled slot, then inserts or drops; a hit ends the scan at
// its slot. The key memory's single read port compares one stored key per cycle.
// Reset clears only the fill count and control state; the tables need no clearing pass.
// A finished result waits in the output register while the next sample is accepted and
// scanned; the scan stalls at its end only if that register is still occupied.
module keyed_duration_accumulator (
  input  logic          clk_i,
  input  logic          rst_ni,
  kda_sample_if.sink    sample_i,
  kda_result_if.source  result_o
);

  kda_pkg::dp_cmd_t    cmd;
  kda_pkg::dp_status_t dp_status;

  kda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  kda_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .key_address_i    (sample_i.key_address),
    .duration_ticks_i (sample_i.duration_ticks),
    .cmd_i            (cmd),
    .status_o         (dp_status),
    .status_field_o   (result_o.status),
    .entry_index_o    (result_o.entry_index),
    .total_ticks_o    (result_o.total_ticks),
    .call_count_o     (result_o.call_count)
  );

endmodule

>>> sim/kda_tally_checker.sv
`timescale 1ns / 1ps
// Checker for the keyed duration accumulator: mirrors the key table and scores every result beat.
module kda_tally_checker
  import kda_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  kda_sample_if sample_i,
  kda_result_if result_i,
  output int    mismatches_o,
  output int    pending_o
);

  localparam int TABLE_DEPTH = int'(ENTRIES);
  localparam int PRINT_CAP   = 50;

  // One predicted result beat.
  typedef struct packed {
    status_e            status;
    logic [EIDX_W-1:0]  entry_index;
    logic [TOTAL_W-1:0] total_ticks;
    logic [COUNT_W-1:0] call_count;
  } tally_t;

  // Mirror of the block's key table.
  logic [KEY_W-1:0]   slot_key   [TABLE_DEPTH];
  logic [TOTAL_W-1:0] slot_total [TABLE_DEPTH];
  logic [COUNT_W-1:0] slot_count [TABLE_DEPTH];
  int                 slots_filled;

  tally_t tally_q[$];
  int     mismatch_count = 0;
  int     result_num;

  assign mismatches_o = mismatch_count;

  // Look the key up from slot 0 upward, then update, append or drop.
  function automatic tally_t accumulate_sample(input logic [KEY_W-1:0]   key,
                                               input logic [TOTAL_W-1:0] ticks);
    tally_t t;
    int     hit_slot;
    hit_slot = -1;
    for (int s = 0; s < slots_filled; s++) begin
      if (hit_slot < 0 && slot_key[s] == key) hit_slot = s;
    end
    if (hit_slot >= 0) begin
      slot_total[hit_slot] += ticks;
      // The count saturates rather than wrapping.
      if (slot_count[hit_slot] != COUNT_MAX) slot_count[hit_slot] += 1'b1;
      t.status      = ST_UPDATED;
      t.entry_index = hit_slot[EIDX_W-1:0];
      t.total_ticks = slot_total[hit_slot];
      t.call_count  = slot_count[hit_slot];
    end else if (slots_filled >= TABLE_DEPTH) begin
      // Table full and key absent: the sample is dropped, the table is left alone.
      t.status      = ST_FULL;
      t.entry_index = '0;
      t.total_ticks = '0;
      t.call_count  = '0;
    end else begin
      slot_key[slots_filled]   = key;
      slot_total[slots_filled] = ticks;
      slot_count[slots_filled] = 1;
      t.status      = ST_INSERTED;
      t.entry_index = slots_filled[EIDX_W-1:0];
      t.total_ticks = ticks;
      t.call_count  = 1;
      slots_filled++;
    end
    return t;
  endfunction

  // Prints one line per mismatch, up to a cap, and counts all of them.
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("%0t: result %0d: %s", $time, result_num, msg);
  endtask

  // Score result beats against the oldest prediction, then predict for new sample beats.
  always @(posedge clk_i or negedge rst_ni) begin : score
    tally_t want;
    if (!rst_ni) begin
      slots_filled = 0;
      result_num   = 0;
      tally_q.delete();
      pending_o <= 0;
    end else begin
      if (result_i.valid && result_i.ready) begin
        if (tally_q.size() == 0) begin
          report_mismatch("result beat with no sample outstanding");
        end else begin
          want = tally_q.pop_front();
          if (result_i.status !== want.status)
            report_mismatch($sformatf("status %h, expected %h", result_i.status, want.status));
          if (result_i.entry_index !== want.entry_index)
            report_mismatch($sformatf("entry_index %0d, expected %0d",
                                      result_i.entry_index, want.entry_index));
          if (result_i.total_ticks !== want.total_ticks)
            report_mismatch($sformatf("total_ticks %h, expected %h",
                                      result_i.total_ticks, want.total_ticks));
          if (result_i.call_count !== want.call_count)
            report_mismatch($sformatf("call_count %h, expected %h",
                                      result_i.call_count, want.call_count));
        end
        result_num++;
      end
      if (sample_i.valid && sample_i.ready)
        tally_q.push_back(accumulate_sample(sample_i.key_address, sample_i.duration_ticks));
      pending_o <= tally_q.size();
    end
  end

endmodule

>>> sim/keyed_duration_accumulator_test.sv
`timescale 1ns / 1ps
// Testbench top for the keyed duration accumulator: sample stimulus, result draining and verdict.
module keyed_duration_accumulator_test;
  import kda_pkg::*;

  localparam int RANDOM_SAMPLES = 837;
  localparam int CYCLE_LIMIT    = 500_000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int HOLD_START     = 2000;
  localparam int HOLD_CYCLES    = 700;

  logic clk_i;
  logic rst_ni;
  int   mismatches;
  int   outstanding;
  int   burst_left;

  logic [KEY_W-1:0] known_keys[$];
  logic [KEY_W-1:0] last_key;

  kda_sample_if sample_ch ();
  kda_result_if result_ch ();

  keyed_duration_accumulator uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_ch),
    .result_o (result_ch)
  );

  kda_tally_checker tally_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (sample_ch),
    .result_i     (result_ch),
    .mismatches_o (mismatches),
    .pending_o    (outstanding)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random short stalls in alternate windows, plus one long hold-off that
  // backs the block up while samples keep coming.
  initial begin : drain
    int cyc;
    int stall_left;
    cyc        = 0;
    stall_left = 0;
    result_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
        result_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= 1'b1;
        if (cyc[9] && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 12);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Durations: mostly small or fully random, some close to the top to force wraps.
  function automatic logic [TOTAL_W-1:0] pick_ticks();
    case ($urandom_range(0, 4))
      0, 1:    return TOTAL_W'($urandom_range(0, 1000));
      2:       return {32'hFFFF_FFFF, $urandom()};
      default: return rand64();
    endcase
  endfunction

  // Offers one sample beat and waits for it to be taken; gaps fall between bursts.
  task automatic send_sample(input logic [KEY_W-1:0] key, input logic [TOTAL_W-1:0] ticks);
    int gap;
    sample_ch.valid          <= 1'b1;
    sample_ch.key_address    <= key;
    sample_ch.duration_ticks <= ticks;
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
    last_key = key;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 23);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin : stimulus
    logic [KEY_W-1:0] key;
    int               sel;
    rst_ni                   <= 1'b0;
    sample_ch.valid          <= 1'b0;
    sample_ch.key_address    <= '0;
    sample_ch.duration_ticks <= '0;
    burst_left = 0;
    last_key   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme keys and durations, hits right after inserts, total wrap-around.
    send_sample(64'h0, 64'h0);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(64'h0, 64'h1);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 64'h2);
    send_sample(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_sample(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_sample(64'h1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(64'h7FFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555);
    send_sample(64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
    send_sample(64'h5555_5555_5555_5555, 64'hFFFF_FFFF_0000_0000);
    send_sample(64'h1, 64'h1);
    send_sample(64'h0, 64'h0);
    known_keys = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h1,
                   64'h7FFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};

    // Random: mostly hits on stored keys, new keys until the table fills (then drops),
    // and near-miss or repeated keys. The count cannot saturate within one run.
    for (int n = 0; n < RANDOM_SAMPLES; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        key = known_keys[$urandom_range(0, known_keys.size() - 1)];
      end else if (sel < 80) begin
        key = rand64();
        if (known_keys.size() < int'(ENTRIES)) known_keys.push_back(key);
      end else if (sel < 90) begin
        key = last_key ^ (64'd1 << $urandom_range(0, 63));
      end else begin
        key = last_key;
      end
      send_sample(key, pick_ticks());
    end
    sample_ch.valid <= 1'b0;

    // Wait for every result, then a little longer to catch stray beats.
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/kda_pkg.sv
hdl/kda_sample_if.sv
hdl/kda_result_if.sv
hdl/kda_ram.sv
hdl/kda_ctrl.sv
hdl/kda_dp.sv
hdl/keyed_duration_accumulator.sv
sim/kda_tally_checker.sv
sim/keyed_duration_accumulator_test.sv
